FILE: hw/rtl/lgs_pkg.sv
`default_nettype none

package lgs_pkg;

    localparam int ROW_W        = 32;
    localparam int GRID_DEFAULT = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        RULE_B3S23     = 1'b0,
        RULE_ORTH_B1S4 = 1'b1
    } lgs_rule_t;

    // column bits a cell shares with its neighbors
    typedef struct packed {
        logic up;
        logic mid;
        logic dn;
    } lgs_nbr_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             fe;
    } lgs_entry_t;

    // pushes into the output queue for one accepted row
    typedef struct packed {
        logic             row_en;
        logic [ROW_W-1:0] row;
        logic             end_en;
    } lgs_push_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lgs_cell.sv
`default_nettype none

module lgs_cell
    import lgs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      adv,
    input  wire logic      clr,
    input  wire lgs_rule_t mode,
    input  wire logic      dn,
    input  wire lgs_nbr_t  left,
    input  wire lgs_nbr_t  right,
    output lgs_nbr_t       self,
    output logic           next_bit
);

    logic       up_reg, up_next;
    logic       mid_reg, mid_next;
    logic [2:0] orth;
    logic [3:0] n8;

    assign self = '{up: up_reg, mid: mid_reg, dn: dn};

    assign orth = 3'(left.mid) + 3'(right.mid) + 3'(up_reg) + 3'(dn);
    assign n8   = 4'(orth) + 4'(left.up) + 4'(left.dn) + 4'(right.up) + 4'(right.dn);

    always_comb
    begin
        unique case (mode)
            RULE_B3S23:
                next_bit = mid_reg ? (n8 == 4'd2 || n8 == 4'd3) : (n8 == 4'd3);
            RULE_ORTH_B1S4:
                next_bit = mid_reg ? (orth == 3'd4) : (orth == 3'd1);
            default:
                next_bit = 1'b0;
        endcase
    end

    always_comb
    begin
        up_next  = up_reg;
        mid_next = mid_reg;
        if (adv)
        begin
            up_next  = clr ? 1'b0 : mid_reg;
            mid_next = clr ? 1'b0 : dn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg  <= 1'b0;
            mid_reg <= 1'b0;
        end
        else
        begin
            up_reg  <= up_next;
            mid_reg <= mid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lgs_out_queue.sv
`default_nettype none

module lgs_out_queue
    import lgs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lgs_push_t        push,
    output logic                  room,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [ROW_W-1:0]      next_row_bits,
    output logic                  frame_end
);

    lgs_entry_t            mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic [QUEUE_AW-1:0]   end_slot;
    logic                  pop;
    logic [QUEUE_CW-1:0]   n_push;

    assign out_valid     = (count_reg != '0);
    assign next_row_bits = mem[rd_ptr_reg].row;
    assign frame_end     = mem[rd_ptr_reg].fe;
    // a row can bring two words, so keep two slots free
    assign room          = (count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2));

    assign pop      = out_valid && !out_stall;
    assign n_push   = QUEUE_CW'(push.row_en) + QUEUE_CW'(push.end_en);
    assign end_slot = wr_ptr_reg + QUEUE_AW'(push.row_en);

    assign wr_ptr_next = wr_ptr_reg + QUEUE_AW'(n_push);
    assign rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
    assign count_next  = count_reg + n_push - QUEUE_CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.row_en)
            mem[wr_ptr_reg] <= '{row: push.row, fe: 1'b0};
        if (push.end_en)
            mem[end_slot] <= '{row: '0, fe: 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/life_generation_step.sv
`default_nettype none

// channel   dir  handshake             payload
// in        in   in_valid / in_stall   row_bits[31:0]
// out       out  out_valid / out_stall next_row_bits[31:0], frame_end
// cfg       in   cfg_wr_en             cfg_wr_data (rule mode)
//
// One row word per cycle while in_stall is low; all 32 column cells evaluate the row in the cycle
// it is accepted, and the result is registered into a 4-word output queue.
// The last row of a frame pushes two words (the result for the row above it plus the dead bottom row).
// in_stall rises only when the queue holds more than two words.
// Reset clears the row history, the row count, the queue and the rule mode.

module life_generation_step
    import lgs_pkg::*;
#(
    parameter int GRID_SIZE = GRID_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [ROW_W-1:0] row_bits,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [ROW_W-1:0]      next_row_bits,
    output logic                  frame_end,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_wr_data
);

    localparam int CNT_W    = $clog2(GRID_SIZE);
    localparam int LAST_COL = (GRID_SIZE - 2 > ROW_W - 1) ? ROW_W - 1 : GRID_SIZE - 2;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(GRID_SIZE - 1);

    lgs_rule_t          mode_reg, mode_next;
    logic [CNT_W-1:0]   row_cnt_reg, row_cnt_next;
    logic               accept;
    logic               last_row;
    logic               room;
    logic [ROW_W-1:0]   row_in;
    logic [ROW_W-1:0]   cell_bits;
    lgs_nbr_t           nbr [ROW_W];
    lgs_push_t          push;

    assign accept   = in_valid && !in_stall;
    assign in_stall = !room;
    assign last_row = (row_cnt_reg == LAST_IDX);

    genvar j;
    generate
        for (j = 0; j < ROW_W; j++)
        begin : g_col
            lgs_nbr_t left_n;
            lgs_nbr_t right_n;
            logic     nb;

            // columns past the grid read as dead
            assign row_in[j] = (j < GRID_SIZE) ? row_bits[j] : 1'b0;

            if (j == 0)
            begin : g_l0
                assign left_n = '0;
            end
            else
            begin : g_l
                assign left_n = nbr[j-1];
            end

            if (j == ROW_W - 1)
            begin : g_r0
                assign right_n = '0;
            end
            else
            begin : g_r
                assign right_n = nbr[j+1];
            end

            lgs_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (accept),
                .clr      (last_row),
                .mode     (mode_reg),
                .dn       (row_in[j]),
                .left     (left_n),
                .right    (right_n),
                .self     (nbr[j]),
                .next_bit (nb)
            );

            // outer ring stays dead
            assign cell_bits[j] = (j >= 1 && j <= LAST_COL) ? nb : 1'b0;
        end
    endgenerate

    always_comb
    begin
        push.row_en = accept && (row_cnt_reg != '0);
        push.row    = (row_cnt_reg > CNT_W'(1)) ? cell_bits : '0;
        push.end_en = accept && last_row;
    end

    lgs_out_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .room          (room),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .next_row_bits (next_row_bits),
        .frame_end     (frame_end)
    );

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        if (accept)
            row_cnt_next = last_row ? '0 : row_cnt_reg + CNT_W'(1);
        mode_next = cfg_wr_en ? lgs_rule_t'(cfg_wr_data) : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            mode_reg    <= RULE_B3S23;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            mode_reg    <= mode_next;
        end
    end

    a_end_word_dead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> next_row_bits == '0)
        else $error("frame end word carries live cells");

    a_left_ring_dead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !next_row_bits[0])
        else $error("left ring column alive");

    a_count_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_row |=> row_cnt_reg == '0)
        else $error("row count did not wrap after last row");

    a_empty_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty queue");

endmodule

`default_nettype wire
